@@ rtl/chrt_pkg.sv @@
// Shared types, widths and the multiply-accumulate step table for the closest-hit block.
// No dependencies; every other file refers to it by scoped names.
package chrt_pkg;

	localparam int COORD_BITS = 32;
	localparam int FRAC_BITS  = 16;
	localparam int MUL_DIGIT  = 4;

	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int CROSS_W = 2 * DIFF_W + 1;
	localparam int DOT_W   = 3 * DIFF_W + 3;
	localparam int NUM_W   = DOT_W + FRAC_BITS;
	localparam int PROD_W  = CROSS_W + DIFF_W;
	localparam int MUL_STEPS = (DIFF_W + MUL_DIGIT - 1) / MUL_DIGIT;
	localparam int MUL_CNT_W = (MUL_STEPS > 1) ? $clog2(MUL_STEPS) : 1;
	localparam int DIV_CNT_W = $clog2(COORD_BITS);

	localparam int NSTEP  = 24;
	localparam int STEP_W = $clog2(NSTEP);

	localparam logic [COORD_BITS-1:0] DIST_MAX  = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic [COORD_BITS-1:0] DIST_MIN  = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam logic [COORD_BITS-1:0] MISS_DIST =
		COORD_BITS'(-(longint'(1) <<< FRAC_BITS));

	localparam logic [4:0] SRC_E1_0 = 5'd0;
	localparam logic [4:0] SRC_E1_1 = 5'd1;
	localparam logic [4:0] SRC_E1_2 = 5'd2;
	localparam logic [4:0] SRC_E2_0 = 5'd3;
	localparam logic [4:0] SRC_E2_1 = 5'd4;
	localparam logic [4:0] SRC_E2_2 = 5'd5;
	localparam logic [4:0] SRC_S_0  = 5'd6;
	localparam logic [4:0] SRC_S_1  = 5'd7;
	localparam logic [4:0] SRC_S_2  = 5'd8;
	localparam logic [4:0] SRC_D_0  = 5'd9;
	localparam logic [4:0] SRC_D_1  = 5'd10;
	localparam logic [4:0] SRC_D_2  = 5'd11;
	localparam logic [4:0] SRC_P_0  = 5'd12;
	localparam logic [4:0] SRC_P_1  = 5'd13;
	localparam logic [4:0] SRC_P_2  = 5'd14;
	localparam logic [4:0] SRC_Q_0  = 5'd15;
	localparam logic [4:0] SRC_Q_1  = 5'd16;
	localparam logic [4:0] SRC_Q_2  = 5'd17;

	localparam logic [3:0] DST_P0  = 4'd0;
	localparam logic [3:0] DST_P1  = 4'd1;
	localparam logic [3:0] DST_P2  = 4'd2;
	localparam logic [3:0] DST_Q0  = 4'd3;
	localparam logic [3:0] DST_Q1  = 4'd4;
	localparam logic [3:0] DST_Q2  = 4'd5;
	localparam logic [3:0] DST_DET = 4'd6;
	localparam logic [3:0] DST_UN  = 4'd7;
	localparam logic [3:0] DST_VN  = 4'd8;
	localparam logic [3:0] DST_TN  = 4'd9;

	typedef struct packed {
		logic                          func;
		logic                          last;
		logic signed [COORD_BITS-1:0]  p0_x;
		logic signed [COORD_BITS-1:0]  p0_y;
		logic signed [COORD_BITS-1:0]  p0_z;
		logic signed [COORD_BITS-1:0]  p1_x;
		logic signed [COORD_BITS-1:0]  p1_y;
		logic signed [COORD_BITS-1:0]  p1_z;
		logic signed [COORD_BITS-1:0]  p2_x;
		logic signed [COORD_BITS-1:0]  p2_y;
		logic signed [COORD_BITS-1:0]  p2_z;
	} item_t;

	typedef struct packed {
		logic                          hit;
		logic signed [COORD_BITS-1:0]  distance;
	} result_t;

	typedef struct packed {
		logic [4:0] a_sel;
		logic [4:0] b_sel;
		logic       first;
		logic       neg;
		logic       last;
		logic [3:0] dst;
	} step_t;

	typedef struct packed {
		logic              load_ray;
		logic              load_tri;
		logic              mac_go;
		logic [STEP_W-1:0] step;
		logic              norm;
		logic              div_go;
		logic              commit;
		logic              emit;
	} cmd_t;

	typedef struct packed {
		logic mac_busy;
		logic div_busy;
		logic reject;
		logic out_busy;
	} status_t;

	function automatic step_t mk(logic [4:0] a, logic [4:0] b, logic f, logic n, logic l,
		logic [3:0] d);
		step_t r;
		r.a_sel = a;
		r.b_sel = b;
		r.first = f;
		r.neg   = n;
		r.last  = l;
		r.dst   = d;
		return r;
	endfunction

	function automatic step_t mac_step(logic [STEP_W-1:0] idx);
		step_t r;
		unique case (idx)
			5'd0:  r = mk(SRC_D_1,  SRC_E2_2, 1'b1, 1'b0, 1'b0, DST_P0);
			5'd1:  r = mk(SRC_D_2,  SRC_E2_1, 1'b0, 1'b1, 1'b1, DST_P0);
			5'd2:  r = mk(SRC_D_2,  SRC_E2_0, 1'b1, 1'b0, 1'b0, DST_P1);
			5'd3:  r = mk(SRC_D_0,  SRC_E2_2, 1'b0, 1'b1, 1'b1, DST_P1);
			5'd4:  r = mk(SRC_D_0,  SRC_E2_1, 1'b1, 1'b0, 1'b0, DST_P2);
			5'd5:  r = mk(SRC_D_1,  SRC_E2_0, 1'b0, 1'b1, 1'b1, DST_P2);
			5'd6:  r = mk(SRC_S_1,  SRC_E1_2, 1'b1, 1'b0, 1'b0, DST_Q0);
			5'd7:  r = mk(SRC_S_2,  SRC_E1_1, 1'b0, 1'b1, 1'b1, DST_Q0);
			5'd8:  r = mk(SRC_S_2,  SRC_E1_0, 1'b1, 1'b0, 1'b0, DST_Q1);
			5'd9:  r = mk(SRC_S_0,  SRC_E1_2, 1'b0, 1'b1, 1'b1, DST_Q1);
			5'd10: r = mk(SRC_S_0,  SRC_E1_1, 1'b1, 1'b0, 1'b0, DST_Q2);
			5'd11: r = mk(SRC_S_1,  SRC_E1_0, 1'b0, 1'b1, 1'b1, DST_Q2);
			5'd12: r = mk(SRC_P_0,  SRC_E1_0, 1'b1, 1'b0, 1'b0, DST_DET);
			5'd13: r = mk(SRC_P_1,  SRC_E1_1, 1'b0, 1'b0, 1'b0, DST_DET);
			5'd14: r = mk(SRC_P_2,  SRC_E1_2, 1'b0, 1'b0, 1'b1, DST_DET);
			5'd15: r = mk(SRC_P_0,  SRC_S_0,  1'b1, 1'b0, 1'b0, DST_UN);
			5'd16: r = mk(SRC_P_1,  SRC_S_1,  1'b0, 1'b0, 1'b0, DST_UN);
			5'd17: r = mk(SRC_P_2,  SRC_S_2,  1'b0, 1'b0, 1'b1, DST_UN);
			5'd18: r = mk(SRC_Q_0,  SRC_D_0,  1'b1, 1'b0, 1'b0, DST_VN);
			5'd19: r = mk(SRC_Q_1,  SRC_D_1,  1'b0, 1'b0, 1'b0, DST_VN);
			5'd20: r = mk(SRC_Q_2,  SRC_D_2,  1'b0, 1'b0, 1'b1, DST_VN);
			5'd21: r = mk(SRC_Q_0,  SRC_E2_0, 1'b1, 1'b0, 1'b0, DST_TN);
			5'd22: r = mk(SRC_Q_1,  SRC_E2_1, 1'b0, 1'b0, 1'b0, DST_TN);
			5'd23: r = mk(SRC_Q_2,  SRC_E2_2, 1'b0, 1'b0, 1'b1, DST_TN);
			default: r = mk(SRC_E1_0, SRC_E1_0, 1'b1, 1'b0, 1'b0, DST_P0);
		endcase
		return r;
	endfunction

endpackage

@@ rtl/chrt_ctrl.sv @@
// Sequencer for the closest-hit block: walks the multiply-accumulate table, the divide
// and the update. Depends on chrt_pkg for the command, status and step constants.
module chrt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic              func,
	input  logic              last,
	input  chrt_pkg::status_t status,
	output chrt_pkg::cmd_t    cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ISSUE  = 3'd1;
	localparam logic [2:0] S_MUL    = 3'd2;
	localparam logic [2:0] S_NORM   = 3'd3;
	localparam logic [2:0] S_CHECK  = 3'd4;
	localparam logic [2:0] S_DIV    = 3'd5;
	localparam logic [2:0] S_COMMIT = 3'd6;
	localparam logic [2:0] S_EMIT   = 3'd7;

	logic [2:0]                  state_q, state_nx;
	logic [chrt_pkg::STEP_W-1:0] step_q, step_nx;
	logic                        last_q, last_nx;

	assign item_ready = (state_q == S_IDLE);

	always_comb begin
		state_nx = state_q;
		step_nx  = step_q;
		last_nx  = last_q;
		cmd      = '0;
		cmd.step = step_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					last_nx = last;
					if (!func) begin
						cmd.load_ray = 1'b1;
						state_nx     = last ? S_EMIT : S_IDLE;
					end else begin
						cmd.load_tri = 1'b1;
						step_nx      = '0;
						state_nx     = S_ISSUE;
					end
				end
			end
			S_ISSUE: begin
				cmd.mac_go = 1'b1;
				state_nx   = S_MUL;
			end
			S_MUL: begin
				if (!status.mac_busy) begin
					if (step_q == chrt_pkg::STEP_W'(chrt_pkg::NSTEP - 1)) begin
						state_nx = S_NORM;
					end else begin
						step_nx  = step_q + 1'b1;
						state_nx = S_ISSUE;
					end
				end
			end
			S_NORM: begin
				cmd.norm = 1'b1;
				state_nx = S_CHECK;
			end
			S_CHECK: begin
				if (status.reject) begin
					state_nx = last_q ? S_EMIT : S_IDLE;
				end else begin
					cmd.div_go = 1'b1;
					state_nx   = S_DIV;
				end
			end
			S_DIV: begin
				if (!status.div_busy) begin
					state_nx = S_COMMIT;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_nx   = last_q ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				if (!status.out_busy) begin
					cmd.emit = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			step_q  <= step_nx;
			last_q  <= last_nx;
		end
	end

endmodule

@@ rtl/chrt_datapath.sv @@
// Datapath of the closest-hit block: ray and edge registers, a digit-serial multiply-
// accumulate unit, a restoring divider and the result register. Depends on chrt_pkg.
module chrt_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  chrt_pkg::item_t   item,
	input  chrt_pkg::cmd_t    cmd,
	output chrt_pkg::status_t status,
	output logic              result_valid,
	input  logic              result_ready,
	output chrt_pkg::result_t result
);

	localparam int CB  = chrt_pkg::COORD_BITS;
	localparam int DW  = chrt_pkg::DIFF_W;
	localparam int CW  = chrt_pkg::CROSS_W;
	localparam int PW  = chrt_pkg::DOT_W;
	localparam int NW  = chrt_pkg::NUM_W;
	localparam int MW  = chrt_pkg::PROD_W;
	localparam int RD  = chrt_pkg::MUL_DIGIT;
	localparam int MCW = chrt_pkg::MUL_CNT_W;
	localparam int DCW = chrt_pkg::DIV_CNT_W;

	logic signed [CB-1:0] org_q [3];
	logic signed [CB-1:0] dir_q [3];
	logic signed [DW-1:0] e1_q  [3];
	logic signed [DW-1:0] e2_q  [3];
	logic signed [DW-1:0] s_q   [3];
	logic signed [CW-1:0] p_q   [3];
	logic signed [CW-1:0] q_q   [3];
	logic signed [PW-1:0] det_q, un_q, vn_q, tn_q, acc_q;
	logic signed [CB-1:0] closest_q;
	logic                 hit_q;

	logic                 mbusy_q, msign_q;
	logic [MCW-1:0]       mcnt_q;
	logic [MW-1:0]        ma_q, prod_q;
	logic [DW-1:0]        mb_q;
	chrt_pkg::step_t      st_q, st_go;

	logic                 dbusy_q, tneg_q, ovf_q;
	logic [DCW-1:0]       dcnt_q;
	logic [PW:0]          rem_q;
	logic [CB-1:0]        nlo_q, quo_q;

	logic signed [CB-1:0] pa [3];
	logic signed [CB-1:0] pb [3];
	logic signed [CB-1:0] pc [3];

	assign pa[0] = item.p0_x;
	assign pa[1] = item.p0_y;
	assign pa[2] = item.p0_z;
	assign pb[0] = item.p1_x;
	assign pb[1] = item.p1_y;
	assign pb[2] = item.p1_z;
	assign pc[0] = item.p2_x;
	assign pc[1] = item.p2_y;
	assign pc[2] = item.p2_z;

	assign st_go = chrt_pkg::mac_step(cmd.step);

	function automatic logic signed [DW-1:0] narrow_src(logic [4:0] sel,
		logic signed [DW-1:0] e1 [3], logic signed [DW-1:0] e2 [3],
		logic signed [DW-1:0] s [3], logic signed [CB-1:0] d [3]);
		logic signed [DW-1:0] r;
		case (sel)
			chrt_pkg::SRC_E1_0: r = e1[0];
			chrt_pkg::SRC_E1_1: r = e1[1];
			chrt_pkg::SRC_E1_2: r = e1[2];
			chrt_pkg::SRC_E2_0: r = e2[0];
			chrt_pkg::SRC_E2_1: r = e2[1];
			chrt_pkg::SRC_E2_2: r = e2[2];
			chrt_pkg::SRC_S_0:  r = s[0];
			chrt_pkg::SRC_S_1:  r = s[1];
			chrt_pkg::SRC_S_2:  r = s[2];
			chrt_pkg::SRC_D_0:  r = DW'(d[0]);
			chrt_pkg::SRC_D_1:  r = DW'(d[1]);
			chrt_pkg::SRC_D_2:  r = DW'(d[2]);
			default:            r = '0;
		endcase
		return r;
	endfunction

	logic signed [CW-1:0] a_val;
	logic signed [DW-1:0] b_val;
	logic [CW-1:0]        a_mag;
	logic [DW-1:0]        b_mag;

	always_comb begin
		case (st_go.a_sel)
			chrt_pkg::SRC_P_0: a_val = p_q[0];
			chrt_pkg::SRC_P_1: a_val = p_q[1];
			chrt_pkg::SRC_P_2: a_val = p_q[2];
			chrt_pkg::SRC_Q_0: a_val = q_q[0];
			chrt_pkg::SRC_Q_1: a_val = q_q[1];
			chrt_pkg::SRC_Q_2: a_val = q_q[2];
			default: a_val = CW'(narrow_src(st_go.a_sel, e1_q, e2_q, s_q, dir_q));
		endcase
		b_val = narrow_src(st_go.b_sel, e1_q, e2_q, s_q, dir_q);
		a_mag = a_val[CW-1] ? CW'(-a_val) : CW'(a_val);
		b_mag = b_val[DW-1] ? DW'(-b_val) : DW'(b_val);
	end

	logic [MW-1:0]        prod_nx;
	logic signed [PW-1:0] prod_ext, term, acc_nx;

	always_comb begin
		prod_nx  = prod_q + MW'(ma_q * mb_q[RD-1:0]);
		prod_ext = $signed({{(PW-MW){1'b0}}, prod_nx});
		term     = (msign_q ^ st_q.neg) ? -prod_ext : prod_ext;
		acc_nx   = st_q.first ? term : acc_q + term;
	end

	logic [PW-1:0]  tn_abs;
	logic [NW-1:0]  num;
	logic [PW:0]    trial;
	logic           ge;

	always_comb begin
		tn_abs = tn_q[PW-1] ? PW'(-tn_q) : PW'(tn_q);
		num    = {tn_abs, {chrt_pkg::FRAC_BITS{1'b0}}};
		trial  = {rem_q[PW-1:0], nlo_q[CB-1]};
		ge     = trial >= {1'b0, det_q};
	end

	logic signed [PW:0]   uv_sum;
	logic signed [CB-1:0] t_val;

	always_comb begin
		uv_sum = (PW+1)'(un_q) + (PW+1)'(vn_q);
		status.reject = (det_q == '0) || un_q[PW-1] || (un_q > det_q) || vn_q[PW-1]
			|| (uv_sum > (PW+1)'(det_q));
		status.mac_busy = mbusy_q;
		status.div_busy = dbusy_q;
		status.out_busy = result_valid && !result_ready;
		if (!tneg_q) begin
			t_val = (ovf_q || quo_q[CB-1]) ? chrt_pkg::DIST_MAX : quo_q;
		end else begin
			t_val = (ovf_q || quo_q > chrt_pkg::DIST_MIN) ? chrt_pkg::DIST_MIN : -quo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				org_q[i] <= '0;
				dir_q[i] <= '0;
			end
			closest_q    <= chrt_pkg::DIST_MAX;
			hit_q        <= 1'b0;
			mbusy_q      <= 1'b0;
			dbusy_q      <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (cmd.load_ray) begin
				org_q[0]  <= pa[0];
				org_q[1]  <= pa[1];
				org_q[2]  <= pa[2];
				dir_q[0]  <= pb[0];
				dir_q[1]  <= pb[1];
				dir_q[2]  <= pb[2];
				closest_q <= chrt_pkg::DIST_MAX;
				hit_q     <= 1'b0;
			end
			if (cmd.mac_go) begin
				mbusy_q <= 1'b1;
			end else if (mbusy_q && mcnt_q == MCW'(chrt_pkg::MUL_STEPS - 1)) begin
				mbusy_q <= 1'b0;
			end
			if (cmd.div_go) begin
				dbusy_q <= 1'b1;
			end else if (dbusy_q && dcnt_q == DCW'(CB - 1)) begin
				dbusy_q <= 1'b0;
			end
			if (cmd.commit && t_val <= closest_q) begin
				closest_q <= t_val;
				hit_q     <= 1'b1;
			end
			if (cmd.emit) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_tri) begin
			for (int i = 0; i < 3; i++) begin
				e1_q[i] <= DW'(pb[i]) - DW'(pa[i]);
				e2_q[i] <= DW'(pc[i]) - DW'(pa[i]);
				s_q[i]  <= DW'(org_q[i]) - DW'(pa[i]);
			end
		end
		if (cmd.mac_go) begin
			st_q    <= st_go;
			ma_q    <= MW'(a_mag);
			mb_q    <= b_mag;
			prod_q  <= '0;
			msign_q <= a_val[CW-1] ^ b_val[DW-1];
			mcnt_q  <= '0;
		end else if (mbusy_q) begin
			ma_q   <= ma_q << RD;
			mb_q   <= mb_q >> RD;
			prod_q <= prod_nx;
			mcnt_q <= mcnt_q + 1'b1;
			if (mcnt_q == MCW'(chrt_pkg::MUL_STEPS - 1)) begin
				acc_q <= acc_nx;
				if (st_q.last) begin
					case (st_q.dst)
						chrt_pkg::DST_P0:  p_q[0] <= CW'(acc_nx);
						chrt_pkg::DST_P1:  p_q[1] <= CW'(acc_nx);
						chrt_pkg::DST_P2:  p_q[2] <= CW'(acc_nx);
						chrt_pkg::DST_Q0:  q_q[0] <= CW'(acc_nx);
						chrt_pkg::DST_Q1:  q_q[1] <= CW'(acc_nx);
						chrt_pkg::DST_Q2:  q_q[2] <= CW'(acc_nx);
						chrt_pkg::DST_DET: det_q  <= acc_nx;
						chrt_pkg::DST_UN:  un_q   <= acc_nx;
						chrt_pkg::DST_VN:  vn_q   <= acc_nx;
						chrt_pkg::DST_TN:  tn_q   <= acc_nx;
						default: ;
					endcase
				end
			end
		end
		if (cmd.norm && det_q[PW-1]) begin
			det_q <= -det_q;
			un_q  <= -un_q;
			vn_q  <= -vn_q;
			tn_q  <= -tn_q;
		end
		if (cmd.div_go) begin
			tneg_q <= tn_q[PW-1];
			ovf_q  <= NW'(num[NW-1:CB]) >= NW'(det_q);
			rem_q  <= (PW+1)'(num[NW-1:CB]);
			nlo_q  <= num[CB-1:0];
			quo_q  <= '0;
			dcnt_q <= '0;
		end else if (dbusy_q) begin
			rem_q  <= ge ? trial - {1'b0, det_q} : trial;
			quo_q  <= {quo_q[CB-2:0], ge};
			nlo_q  <= nlo_q << 1;
			dcnt_q <= dcnt_q + 1'b1;
		end
		if (cmd.emit) begin
			result.hit      <= hit_q;
			result.distance <= hit_q ? closest_q : chrt_pkg::MISS_DIST;
		end
	end

endmodule

@@ rtl/closest_hit_ray_triangle.sv @@
// Closest-hit ray/triangle search, top level: controller plus datapath.
// Depends on chrt_pkg, chrt_ctrl and chrt_datapath.
// A start item loads the ray and, if marked last, sends the controller to the emit state,
// and result_valid is registered from the emit; a triangle's time is set by the single
// digit-serial multiply-accumulate unit, which walks the step table, and by the divider.
// One item in flight at a time. Reset clears the ray to zero and the closest distance to max.
module closest_hit_ray_triangle (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  chrt_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output chrt_pkg::result_t result
);

	chrt_pkg::cmd_t    cmd;
	chrt_pkg::status_t status;

	chrt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.func       (item.func),
		.last       (item.last),
		.status     (status),
		.cmd        (cmd)
	);

	chrt_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	a_tri_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.func |=> !item_ready)
		else $error("triangle transaction did not block input");

	a_mac_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		status.mac_busy |-> !item_ready)
		else $error("input ready while multiplier busy");

	a_units_excl: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_busy |-> !status.mac_busy)
		else $error("divider and multiplier busy together");

endmodule
